/* rtl/sfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// shared constants, register codes and control types of the stereo delay
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int SfdDepth       = 262144;
  localparam int SfdSampleWidth = 16;

  localparam int CfgDataWidth = 18;
  localparam int CfgIdxWidth  = 3;

  localparam int FracBits  = 15;
  localparam int RoundHalf = 16384;

  localparam logic [14:0] FbMax = 15'd32440;
  localparam logic [15:0] Unity = 16'd32768;

  localparam logic [17:0] RstDelayLeft  = 18'd24000;
  localparam logic [17:0] RstDelayRight = 18'd36000;
  localparam logic [14:0] RstFbGain     = 15'd9830;
  localparam logic [15:0] RstWetLevel   = 16'd16384;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DELAY_LEFT  = 3'd0,
    REG_DELAY_RIGHT = 3'd1,
    REG_FB_GAIN     = 3'd2,
    REG_PING_PONG   = 3'd3,
    REG_WET_LEVEL   = 3'd4,
    REG_MONO        = 3'd5,
    REG_BYPASS      = 3'd6
  } cfg_reg_e;

  // effective settings, gains already clamped
  typedef struct packed {
    logic [17:0] delay_l;
    logic [17:0] delay_r;
    logic [14:0] fb;
    logic        ping_pong;
    logic [15:0] wet;
    logic [15:0] dry;
    logic        mono;
    logic        bypass;
  } cfg_t;

  // pipeline control from the top level to each lane
  typedef struct packed {
    logic acc;      // request taken into stage 1
    logic adv1;     // stage 1 moves to stage 2
    logic adv2;     // stage 2 moves to the output register
    logic wr_en;    // stage 1 item writes its store entry
    logic wrapped;  // every store entry has been written once
    logic byp2;     // stage 2 item is a bypass request
  } lane_ctrl_t;

endpackage
`default_nettype wire

/* rtl/sfd_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_cfg
// configuration registers with gain clamping and dry gain derivation
// ----------------------------------------------------------------------------
module sfd_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sfd_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [sfd_pkg::CfgDataWidth-1:0] cfg_data_i,
  output sfd_pkg::cfg_t                         cfg_o
);
  import sfd_pkg::*;

  logic [17:0] delay_l_q, delay_r_q;
  logic [14:0] fb_q;
  logic        pp_q, mono_q, byp_q;
  logic [15:0] wet_q;
  logic [15:0] wet_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_l_q <= RstDelayLeft;
      delay_r_q <= RstDelayRight;
      fb_q      <= RstFbGain;
      pp_q      <= 1'b0;
      wet_q     <= RstWetLevel;
      mono_q    <= 1'b0;
      byp_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DELAY_LEFT:  delay_l_q <= cfg_data_i[17:0];
        REG_DELAY_RIGHT: delay_r_q <= cfg_data_i[17:0];
        REG_FB_GAIN:     fb_q      <= cfg_data_i[14:0];
        REG_PING_PONG:   pp_q      <= cfg_data_i[0];
        REG_WET_LEVEL:   wet_q     <= cfg_data_i[15:0];
        REG_MONO:        mono_q    <= cfg_data_i[0];
        REG_BYPASS:      byp_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign wet_eff = (wet_q > Unity) ? Unity : wet_q;

  always_comb begin
    cfg_o.delay_l   = delay_l_q;
    cfg_o.delay_r   = delay_r_q;
    cfg_o.fb        = (fb_q > FbMax) ? FbMax : fb_q;
    cfg_o.ping_pong = pp_q;
    cfg_o.wet       = wet_eff;
    cfg_o.dry       = Unity - wet_eff;
    cfg_o.mono      = mono_q;
    cfg_o.bypass    = byp_q;
  end

endmodule
`default_nettype wire

/* rtl/sfd_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_lane
// one channel: delay store, read forwarding, feedback write and wet/dry mix
// ----------------------------------------------------------------------------
module sfd_lane #(
  parameter int DELAY_DEPTH  = sfd_pkg::SfdDepth,
  parameter int SAMPLE_WIDTH = sfd_pkg::SfdSampleWidth,
  localparam int AW = $clog2(DELAY_DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sfd_pkg::lane_ctrl_t       ctrl_i,
  input  wire logic [17:0]               delay_i,
  input  wire logic [AW-1:0]             wi_i,     // write index at accept
  input  wire logic [AW-1:0]             wa_i,     // stage 1 write address
  input  wire logic signed [SAMPLE_WIDTH-1:0] smp_i,
  input  wire logic [14:0]               fb_i,
  input  wire logic [15:0]               wet_i,
  input  wire logic [15:0]               dry_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] fb_src_i, // delayed sample fed back
  output logic signed [SAMPLE_WIDTH-1:0] dly_o,    // stage 1 delayed sample
  output logic signed [SAMPLE_WIDTH-1:0] mix_o     // stage 2 result
);
  import sfd_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int DW  = ((AW > 18) ? AW : 18) + 1;
  localparam int FPW = SW + 16;
  localparam int MPW = SW + 17;
  localparam int MSW = SW + 18;

  logic signed [SW-1:0] mem [DELAY_DEPTH];

  // read address
  logic [DW-1:0] d_ext;
  logic [AW-1:0] d_cl;
  logic [AW:0]   p_wide;
  logic [AW-1:0] rd_addr;
  logic          rd_zero;
  logic          rd_fwd;

  // stage 1
  logic signed [SW-1:0] rdata_q, in1_q, fwdv_q;
  logic                 fwd_q, zero_q;
  logic signed [FPW-1:0] fb_prod, fb_rnd;
  logic signed [SW+1:0]  st_sum;
  logic signed [SW-1:0]  st_val;

  // stage 2
  logic signed [MPW-1:0] pd_q, pw_q;
  logic signed [SW-1:0]  in2_q;
  logic signed [MSW-1:0] mix_sum;
  logic signed [SW+2:0]  mix_rnd;
  logic signed [SW-1:0]  mix_sat;

  always_comb begin
    d_ext = DW'(delay_i);
    if (delay_i == 18'd0) begin
      d_cl = AW'(1);
    end else if (d_ext > DW'(DELAY_DEPTH - 1)) begin
      d_cl = AW'(DELAY_DEPTH - 1);
    end else begin
      d_cl = d_ext[AW-1:0];
    end
    if (wi_i >= d_cl) begin
      p_wide = {1'b0, wi_i} - {1'b0, d_cl};
    end else begin
      p_wide = {1'b0, wi_i} + (AW+1)'(DELAY_DEPTH) - {1'b0, d_cl};
    end
    rd_addr = p_wide[AW-1:0];
    // entries at or past the write index are untouched until the first wrap
    rd_zero = !ctrl_i.wrapped && !(rd_addr < wi_i);
    // entry written by the item leaving stage 1 on this same edge
    rd_fwd  = ctrl_i.wr_en && (wa_i == rd_addr);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wa_i] <= st_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= 1'b0;
      zero_q <= 1'b0;
    end else if (ctrl_i.acc) begin
      fwd_q  <= rd_fwd;
      zero_q <= rd_zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc) begin
      in1_q  <= smp_i;
      fwdv_q <= st_val;
    end
  end

  always_comb begin
    if (fwd_q) begin
      dly_o = fwdv_q;
    end else if (zero_q) begin
      dly_o = '0;
    end else begin
      dly_o = rdata_q;
    end
  end

  // feedback: in + round(src * fb / 2^15), saturated
  always_comb begin
    fb_prod = $signed(fb_src_i) * $signed({1'b0, fb_i});
    fb_rnd  = fb_prod + $signed(FPW'(RoundHalf));
    st_sum  = (SW+2)'(in1_q) + (SW+2)'($signed(fb_rnd[FPW-1:FracBits]));
    if (st_sum[SW+1:SW-1] == '0 || st_sum[SW+1:SW-1] == '1) begin
      st_val = st_sum[SW-1:0];
    end else begin
      st_val = st_sum[SW+1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv1) begin
      pd_q  <= $signed(in1_q) * $signed({1'b0, dry_i});
      pw_q  <= $signed(dly_o) * $signed({1'b0, wet_i});
      in2_q <= in1_q;
    end
  end

  // mix: round((in * dry + dly * wet) / 2^15), saturated
  always_comb begin
    mix_sum = MSW'(pd_q) + MSW'(pw_q) + $signed(MSW'(RoundHalf));
    mix_rnd = mix_sum[MSW-1:FracBits];
    if (mix_rnd[SW+2:SW-1] == '0 || mix_rnd[SW+2:SW-1] == '1) begin
      mix_sat = mix_rnd[SW-1:0];
    end else begin
      mix_sat = mix_rnd[SW+2] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    mix_o = ctrl_i.byp2 ? in2_q : mix_sat;
  end

endmodule
`default_nettype wire

/* rtl/stereo_feedback_delay_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_feedback_delay_top
// stereo feedback delay with ping-pong crossing, wet/dry mix and bypass
// ----------------------------------------------------------------------------
// flow: a request accepted on an edge goes through the store read (stage 1),
//   the mix (stage 2) and the output register before its result is valid
// throughput: one stereo pair per cycle while m_axis_tready holds no stall,
//   limited by the one-read one-write port pair of each lane's delay store
// reset: registers take their documented defaults, write index goes to zero;
//   store entries are not cleared, a wrap flag and the write index make
//   never-written entries read as zero, so no clearing pass is needed
// ----------------------------------------------------------------------------
module stereo_feedback_delay_top #(
  parameter int DELAY_DEPTH  = sfd_pkg::SfdDepth,
  parameter int SAMPLE_WIDTH = sfd_pkg::SfdSampleWidth,
  localparam int TW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [sfd_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [sfd_pkg::CfgDataWidth-1:0] cfg_data_i,
  // sample requests in
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [TW-1:0]                    s_axis_tdata,  // left_in, right_in
  // mixed samples out
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [TW-1:0]                         m_axis_tdata   // left_out, right_out
);
  import sfd_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = $clog2(DELAY_DEPTH);

  cfg_t cfg;

  // pipeline occupancy and handshakes
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic acc;
  logic byp1_q, byp2_q;

  // write pointer and fill tracking
  logic [AW-1:0] wi_q, wi_d;
  logic          wrapped_q, wrapped_d;
  logic [AW-1:0] wa1_q;

  lane_ctrl_t ctrl;

  logic signed [SW-1:0] in_l, in_r;
  logic signed [SW-1:0] dly_l, dly_r;
  logic signed [SW-1:0] fbs_l, fbs_r;
  logic signed [SW-1:0] mix_l, mix_r;
  logic signed [SW-1:0] out_l_q, out_r_q;

  sfd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  // each stage moves when the one after it is free or moving
  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign acc  = s_axis_tvalid && rdy1;

  // mono copies the left input onto the right channel, bypass included
  assign in_l = s_axis_tdata[SW-1:0];
  assign in_r = cfg.mono ? s_axis_tdata[SW-1:0] : s_axis_tdata[2*SW-1:SW];

  always_comb begin
    ctrl.acc     = acc;
    ctrl.adv1    = v1_q && rdy2;
    ctrl.adv2    = v2_q && rdy3;
    ctrl.wr_en   = v1_q && rdy2 && !byp1_q;
    ctrl.wrapped = wrapped_q;
    ctrl.byp2    = byp2_q;
  end

  // the write index only moves for requests that touch the stores
  always_comb begin
    wi_d      = wi_q;
    wrapped_d = wrapped_q;
    if (acc && !cfg.bypass) begin
      if (wi_q == AW'(DELAY_DEPTH - 1)) begin
        wi_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wi_d = wi_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      byp1_q    <= 1'b0;
      byp2_q    <= 1'b0;
      wi_q      <= '0;
      wrapped_q <= 1'b0;
    end else begin
      wi_q      <= wi_d;
      wrapped_q <= wrapped_d;
      if (rdy1) begin
        v1_q   <= acc;
        byp1_q <= cfg.bypass;
      end
      if (rdy2) begin
        v2_q   <= v1_q;
        byp2_q <= byp1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      wa1_q <= wi_q;
    end
  end

  // merge: ping-pong crosses the feedback sources between the lanes
  assign fbs_l = cfg.ping_pong ? dly_r : dly_l;
  assign fbs_r = cfg.ping_pong ? dly_l : dly_r;

  sfd_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lane_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .delay_i (cfg.delay_l),
    .wi_i    (wi_q),
    .wa_i    (wa1_q),
    .smp_i   (in_l),
    .fb_i    (cfg.fb),
    .wet_i   (cfg.wet),
    .dry_i   (cfg.dry),
    .fb_src_i(fbs_l),
    .dly_o   (dly_l),
    .mix_o   (mix_l)
  );

  sfd_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lane_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .delay_i (cfg.delay_r),
    .wi_i    (wi_q),
    .wa_i    (wa1_q),
    .smp_i   (in_r),
    .fb_i    (cfg.fb),
    .wet_i   (cfg.wet),
    .dry_i   (cfg.dry),
    .fb_src_i(fbs_r),
    .dly_o   (dly_r),
    .mix_o   (mix_r)
  );

  // output register parts the lanes from the downstream side
  always_ff @(posedge clk_i) begin
    if (ctrl.adv2) begin
      out_l_q <= mix_l;
      out_r_q <= mix_r;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = TW'({out_r_q, out_l_q});

endmodule
`default_nettype wire

/* sim/sfd_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfd_tb_pkg
// expected mixed samples of the stereo feedback delay, kept in a scoreboard
// that mirrors both delay stores, the write index and the register settings
// ----------------------------------------------------------------------------
package sfd_tb_pkg;
  import sfd_pkg::*;

  class delay_scoreboard;
    shortint     left_mem[SfdDepth];
    shortint     right_mem[SfdDepth];
    int          wr_ptr;
    logic [17:0] dly_l;
    logic [17:0] dly_r;
    logic [14:0] fb_gain;
    logic        pp_on;
    logic [15:0] wet_lvl;
    logic        mono_on;
    logic        byp_on;
    logic [15:0] exp_left_q[$];
    logic [15:0] exp_right_q[$];
    int unsigned n_err;
    int unsigned n_checked;

    function new();
      dly_l     = RstDelayLeft;
      dly_r     = RstDelayRight;
      fb_gain   = RstFbGain;
      pp_on     = 1'b0;
      wet_lvl   = RstWetLevel;
      mono_on   = 1'b0;
      byp_on    = 1'b0;
      wr_ptr    = 0;
      n_err     = 0;
      n_checked = 0;
    endfunction

    function int pending();
      return exp_left_q.size();
    endfunction

    function void apply_write(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_DELAY_LEFT:  dly_l   = data[17:0];
        REG_DELAY_RIGHT: dly_r   = data[17:0];
        REG_FB_GAIN:     fb_gain = data[14:0];
        REG_PING_PONG:   pp_on   = data[0];
        REG_WET_LEVEL:   wet_lvl = data[15:0];
        REG_MONO:        mono_on = data[0];
        REG_BYPASS:      byp_on  = data[0];
        default: ;
      endcase
    endfunction

    function longint clamp_sample(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // round half up, then floor
    function longint rnd_q15(longint x);
      return (x + RoundHalf) >>> FracBits;
    endfunction

    // read position behind the write index, delay clamped to 1 .. depth-1
    function int tap(logic [17:0] delay);
      int d;
      int p;
      d = int'(delay);
      if (d < 1) d = 1;
      if (d > SfdDepth - 1) d = SfdDepth - 1;
      p = wr_ptr - d;
      if (p < 0) p += SfdDepth;
      return p;
    endfunction

    function void note_request(logic [15:0] l_raw, logic [15:0] r_raw);
      longint l_in;
      longint r_in;
      longint fb;
      longint wet;
      longint dry;
      longint dl;
      longint dr;
      longint sl;
      longint sr;
      l_in = longint'($signed(l_raw));
      r_in = mono_on ? l_in : longint'($signed(r_raw));
      if (byp_on) begin
        exp_left_q.push_back(16'(l_in));
        exp_right_q.push_back(16'(r_in));
        return;
      end
      fb = longint'(fb_gain);
      if (fb > longint'(FbMax)) fb = longint'(FbMax);
      wet = longint'(wet_lvl);
      if (wet > longint'(Unity)) wet = longint'(Unity);
      dry = longint'(Unity) - wet;
      dl = longint'(left_mem[tap(dly_l)]);
      dr = longint'(right_mem[tap(dly_r)]);
      if (pp_on) begin
        sl = clamp_sample(l_in + rnd_q15(dr * fb));
        sr = clamp_sample(r_in + rnd_q15(dl * fb));
      end else begin
        sl = clamp_sample(l_in + rnd_q15(dl * fb));
        sr = clamp_sample(r_in + rnd_q15(dr * fb));
      end
      left_mem[wr_ptr]  = shortint'(sl);
      right_mem[wr_ptr] = shortint'(sr);
      exp_left_q.push_back(16'(clamp_sample(rnd_q15(l_in * dry + dl * wet))));
      exp_right_q.push_back(16'(clamp_sample(rnd_q15(r_in * dry + dr * wet))));
      wr_ptr = (wr_ptr + 1) % SfdDepth;
    endfunction

    function void check_result(logic [31:0] data);
      logic [15:0] el;
      logic [15:0] er;
      if (exp_left_q.size() == 0) begin
        $error("result with no request pending: left_out %0d, right_out %0d",
               $signed(data[15:0]), $signed(data[31:16]));
        n_err++;
        return;
      end
      el = exp_left_q.pop_front();
      er = exp_right_q.pop_front();
      n_checked++;
      if (data[15:0] !== el) begin
        $error("left_out mismatch: expected %0d, actual %0d", $signed(el), $signed(data[15:0]));
        n_err++;
      end
      if (data[31:16] !== er) begin
        $error("right_out mismatch: expected %0d, actual %0d", $signed(er),
               $signed(data[31:16]));
        n_err++;
      end
    endfunction
  endclass

endpackage

/* sim/tb_stereo_feedback_delay_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_feedback_delay_top
// drives stereo sample requests and register writes into the feedback delay,
// predicts every mixed output pair and compares it field by field
// ----------------------------------------------------------------------------
module tb_stereo_feedback_delay_top;
  import sfd_pkg::*;
  import sfd_tb_pkg::*;

  // an index with no register behind it, writes there must be dropped
  localparam logic [CfgIdxWidth-1:0] RegUnused = 3'd7;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i     = '0;
  logic [CfgDataWidth-1:0] cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [31:0]             s_axis_tdata  = '0;  // left_in, right_in
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [31:0]             m_axis_tdata;        // left_out, right_out

  delay_scoreboard sb;

  // chance in percent that either side sits out a cycle
  int idle_pct   = 37;
  int n_settings = 0;
  int n_bypass   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  stereo_feedback_delay_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // output side: take results and stall at random, values seen are the
  // ones that held just before the edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // one request: random gaps first, then hold valid until it is taken
  task automatic send_pair(input logic [15:0] l, input logic [15:0] r);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(l, r);
    if (sb.byp_on) n_bypass++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // pipeline is three deep, give it a little more
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.apply_write(idx, data);
  endtask

  // full register set, only ever written with the block drained
  task automatic apply_settings(input logic [17:0] dl, input logic [17:0] dr,
                                input logic [17:0] fb, input logic [17:0] pp,
                                input logic [17:0] wet, input logic [17:0] mono,
                                input logic [17:0] byp);
    wait_drained();
    cfg_write(REG_DELAY_LEFT, dl);
    cfg_write(REG_DELAY_RIGHT, dr);
    cfg_write(REG_FB_GAIN, fb);
    cfg_write(REG_PING_PONG, pp);
    cfg_write(REG_WET_LEVEL, wet);
    cfg_write(REG_MONO, mono);
    cfg_write(REG_BYPASS, byp);
    // junk to the unused index must not disturb anything
    cfg_write(RegUnused, 18'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  // sometimes set bits above a register's width, they must be dropped
  function automatic logic [17:0] with_junk(logic [17:0] v, int w);
    logic [17:0] keep;
    keep = (18'h1 << w) - 18'h1;
    if ($urandom_range(3) == 0) return (v & keep) | (18'($urandom) & ~keep);
    return v;
  endfunction

  // mostly short delays so the feedback path sees written samples
  function automatic logic [17:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 18'($urandom_range(1, 48));
    if (r < 88) return 18'($urandom_range(49, 600));
    if (r < 94) return 18'd0;
    if (r < 97) return 18'd262143;
    return 18'($urandom_range(200000, 262143));
  endfunction

  function automatic logic [17:0] pick_fb();
    int r;
    r = $urandom_range(99);
    if (r < 15) return with_junk(18'd0, 15);
    if (r < 30) return with_junk(18'($urandom_range(32441, 32767)), 15);
    return with_junk(18'($urandom_range(0, 32440)), 15);
  endfunction

  function automatic logic [17:0] pick_wet();
    int r;
    r = $urandom_range(99);
    if (r < 15) return with_junk(18'd0, 16);
    if (r < 30) return with_junk(18'd32768, 16);
    if (r < 40) return with_junk(18'($urandom_range(32769, 65535)), 16);
    return with_junk(18'($urandom_range(0, 32768)), 16);
  endfunction

  // full-scale values drive the saturation paths, small ones the rounding
  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h7fff;
    if (r < 20) return 16'h8000;
    if (r < 35) return 16'($urandom_range(600) - 300);
    return 16'($urandom);
  endfunction

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: both delays reach entries never written, so each output
    // is the dry half of its input
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'h8000, 16'h7fff);
    send_pair(16'h0000, 16'hffff);
    send_pair(16'hffff, 16'h0001);
    send_pair(16'h5555, 16'haaaa);

    // zero delay taken as one, feedback and wet above their clamps,
    // stores pile up into saturation
    apply_settings(18'd0, 18'd1, 18'd32767, 18'd0, 18'd65535, 18'd0, 18'd0);
    send_pair(16'h7fff, 16'h7fff);
    send_pair(16'h7fff, 16'h7fff);
    send_pair(16'h7fff, 16'h7fff);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h8000, 16'h8000);

    // ping-pong with mono, all dry: right input is ignored
    apply_settings(18'd2, 18'd3, 18'd32440, 18'd1, 18'd0, 18'd1, 18'd0);
    send_pair(16'h4000, 16'h1234);
    send_pair(16'hc000, 16'h7fff);
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'h8001, 16'h0000);

    // fully wet, outputs show the crossed feedback stores
    apply_settings(18'd2, 18'd3, 18'd32440, 18'd1, 18'd32768, 18'd0, 18'd0);
    send_pair(16'h0100, 16'hff00);
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'h0000, 16'h0000);

    // bypass, then bypass with mono copying left to right
    apply_settings(18'd2, 18'd3, 18'd32440, 18'd1, 18'd32768, 18'd0, 18'd1);
    send_pair(16'h1111, 16'h8000);
    send_pair(16'h7fff, 16'hfedc);
    apply_settings(18'd2, 18'd3, 18'd32440, 18'd1, 18'd32768, 18'd1, 18'd1);
    send_pair(16'h8000, 16'h7fff);
    send_pair(16'h2468, 16'h1357);

    // bypass off again: left reads what was written before bypass, the
    // right delay sits at the store limit
    apply_settings(18'd1, 18'd262143, 18'd9830, 18'd0, 18'd16384, 18'd0, 18'd0);
    send_pair(16'h0001, 16'h7fff);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h7fff, 16'h0002);

    // random settings and samples; one phase runs with no idling at all
    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = (ph == 4) ? 0 : 37;
      apply_settings(pick_delay(), pick_delay(), pick_fb(),
                     with_junk(18'($urandom_range(1)), 1), pick_wet(),
                     with_junk(18'($urandom_range(1)), 1),
                     with_junk(18'($urandom_range(99) < 15), 1));
      for (int k = 0; k < 145; k++) begin
        // sender holds off mid-phase until the pipeline is empty
        if (k == 72 || $urandom_range(299) == 0) wait_drained();
        send_pair(pick_sample(), pick_sample());
      end
    end
    idle_pct = 37;

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // catch any stray result beyond the last one expected
    repeat (10) @(posedge clk_i);

    $display("summary: %0d stereo pairs checked under %0d register settings, %0d in bypass",
             sb.n_checked, n_settings, n_bypass);
    $display("summary: delays from one sample to the store limit, gains at zero, unity and clamped");
    if (sb.n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
